[sv/mvc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvc_pkg: shared types and constants of the multichannel convolution
// Command codes, configuration indexes, fixed field widths, the control word
// that steers one kernel-row cell and the result word.
// ----------------------------------------------------------------------------
package mvc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 4;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 40;
  localparam int POS_W    = 6;
  localparam int CFG_W    = 7;
  localparam int CFG_IX_W = 2;
  localparam int CHAN_W   = 5;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                       shift_en;
    logic                       kload_en;
    logic [IDX_W-1:0]           kload_idx;
    logic signed [SAMPLE_W-1:0] kload_data;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } out_word_t;

endpackage
`default_nettype wire

[sv/multichannel_valid_convolution_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_valid_convolution_top: 2-D valid correlation with channel sum
// Slides a square kernel over each channel plane without padding and sums
// the channel results into one output plane through an accumulator memory.
// ----------------------------------------------------------------------------
// Takes one word per cycle, pixels and coefficient loads alike, and keeps
// that rate through output stalls as long as the output FIFO has room. A
// pixel's result passes in order through the window, the multipliers, the
// row sums, the chain of kernel-row cells and the write into the output
// FIFO; the line buffer read and the accumulator read overlap these.
// Results queue in an output FIFO; input is held off only while the FIFO and
// the words in flight would overflow it. Sums for each output position are
// written into the accumulator on the first channel, added on later ones, and
// delivered during the last channel; no clearing pass is needed after reset.
// Any write to a known register restarts the image at row, column and
// channel zero; coefficients load in order with the pixels around them.
// ----------------------------------------------------------------------------
module multichannel_valid_convolution_top #(
  parameter int KERNEL_SIZE  = 3,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                command_i,
  input  wire logic [mvc_pkg::IDX_W-1:0]           coeff_index_i,
  input  wire logic signed [mvc_pkg::SAMPLE_W-1:0] sample_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [mvc_pkg::SUM_W-1:0]    conv_sum_o,
  output      logic [mvc_pkg::POS_W-1:0]           out_row_o,
  output      logic [mvc_pkg::POS_W-1:0]           out_col_o,
  output      logic                                last_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mvc_pkg::CFG_IX_W-1:0]        cfg_index_i,
  input  wire logic [mvc_pkg::CFG_W-1:0]           cfg_data_i
);

  function automatic int clampi(int v, int lo, int hi);
    int r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  localparam int K     = KERNEL_SIZE;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW    = RW + CW;
  localparam int NS    = KERNEL_SIZE + 4;
  localparam int FD    = 2 ** $clog2(NS + 3);
  localparam int FW    = $clog2(FD);
  localparam int CNTW  = FW + 1;
  localparam int W_RST = clampi(64, KERNEL_SIZE, MAX_WIDTH) - 1;
  localparam int H_RST = clampi(64, KERNEL_SIZE, MAX_HEIGHT) - 1;
  localparam int C_RST = clampi(1, 1, MAX_CHANNELS) - 1;

  typedef struct packed {
    logic          valid;
    logic          emit;
    logic          first_ch;
    logic          last_ch;
    logic          last;
    logic [RW-1:0] orow;
    logic [CW-1:0] ocol;
  } meta_t;

  logic [CW-1:0]  wl_q;
  logic [RW-1:0]  hl_q;
  logic [CHW-1:0] cl_q;
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic [CHW-1:0] ch_q;
  logic           cfg_hit;
  logic           accept;
  logic           is_pixel;
  meta_t          meta_new;
  meta_t          meta_q [1:NS];

  logic                                s1_load_q;
  logic [mvc_pkg::IDX_W-1:0]           s1_idx_q;
  logic signed [mvc_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic [CW-1:0]                       s1_col_q;
  logic                                s2_load_q;
  logic [mvc_pkg::IDX_W-1:0]           s2_idx_q;
  logic signed [mvc_pkg::SAMPLE_W-1:0] s2_sample_q;
  mvc_pkg::cell_ctrl_t                 cell_ctrl;

  logic signed [mvc_pkg::SAMPLE_W-1:0] col_out    [K];
  logic signed [mvc_pkg::SAMPLE_W-1:0] col_in     [K];
  logic signed [mvc_pkg::SUM_W-1:0]    partial    [K];
  logic signed [mvc_pkg::SUM_W-1:0]    partial_in [K];

  logic [mvc_pkg::SUM_W-1:0] acc_rd;
  logic [mvc_pkg::SUM_W-1:0] total;
  logic                      acc_we;
  logic                      push;
  logic                      pop;
  logic                      inc;
  mvc_pkg::out_word_t        fifo_q [FD];
  mvc_pkg::out_word_t        push_word;
  logic [FW-1:0]             wr_ptr_q;
  logic [FW-1:0]             rd_ptr_q;
  logic [CNTW-1:0]           cnt_q;
  logic [CNTW-1:0]           inflight_q;

  // Configuration and position counters
  assign cfg_hit = cfg_we_i && ((cfg_index_i == mvc_pkg::CFG_WIDTH) ||
                                (cfg_index_i == mvc_pkg::CFG_HEIGHT) ||
                                (cfg_index_i == mvc_pkg::CFG_CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= CW'(W_RST);
      hl_q <= RW'(H_RST);
      cl_q <= CHW'(C_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mvc_pkg::CFG_WIDTH: begin
          wl_q <= CW'(clampi(int'(cfg_data_i), K, MAX_WIDTH) - 1);
        end
        mvc_pkg::CFG_HEIGHT: begin
          hl_q <= RW'(clampi(int'(cfg_data_i), K, MAX_HEIGHT) - 1);
        end
        mvc_pkg::CFG_CHANNELS: begin
          cl_q <= CHW'(clampi(int'(cfg_data_i[mvc_pkg::CHAN_W-1:0]), 1, MAX_CHANNELS) - 1);
        end
        default: begin
        end
      endcase
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign is_pixel = (command_i == mvc_pkg::CMD_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ch_q  <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
      ch_q  <= '0;
    end else if (accept && is_pixel) begin
      if (col_q == wl_q) begin
        col_q <= '0;
        if (row_q == hl_q) begin
          row_q <= '0;
          ch_q  <= (ch_q == cl_q) ? '0 : ch_q + CHW'(1);
        end else begin
          row_q <= row_q + RW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_comb begin
    meta_new.valid    = accept && is_pixel;
    meta_new.emit     = (row_q >= RW'(K - 1)) && (col_q >= CW'(K - 1));
    meta_new.first_ch = (ch_q == '0);
    meta_new.last_ch  = (ch_q == cl_q);
    meta_new.last     = (row_q == hl_q) && (col_q == wl_q);
    meta_new.orow     = row_q - RW'(K - 1);
    meta_new.ocol     = col_q - CW'(K - 1);
  end

  // Item pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 1; j <= NS; j++) begin
        meta_q[j] <= '0;
      end
      s1_load_q <= 1'b0;
      s2_load_q <= 1'b0;
    end else begin
      meta_q[1] <= meta_new;
      for (int j = 2; j <= NS; j++) begin
        meta_q[j] <= meta_q[j-1];
      end
      s1_load_q <= accept && !is_pixel;
      s2_load_q <= s1_load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q    <= coeff_index_i;
    s1_sample_q <= sample_i;
    s1_col_q    <= col_q;
    s2_idx_q    <= s1_idx_q;
    s2_sample_q <= s1_sample_q;
  end

  always_comb begin
    cell_ctrl.shift_en   = meta_q[1].valid;
    cell_ctrl.kload_en   = s2_load_q;
    cell_ctrl.kload_idx  = s2_idx_q;
    cell_ctrl.kload_data = s2_sample_q;
  end

  // Chain of kernel-row cells
  generate
    for (genvar g = 0; g < K; g++) begin : g_cell
      if (g == K - 1) begin : g_col_head
        assign col_in[g] = s1_sample_q;
      end else begin : g_col_link
        assign col_in[g] = col_out[g+1];
      end
      if (g == 0) begin : g_sum_head
        assign partial_in[g] = '0;
      end else begin : g_sum_link
        assign partial_in[g] = partial[g-1];
      end

      mvc_cell #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH),
        .CELL_IDX    (g)
      ) u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (cell_ctrl),
        .rd_addr_i (col_q),
        .wr_addr_i (s1_col_q),
        .col_i     (col_in[g]),
        .col_o     (col_out[g]),
        .partial_i (partial_in[g]),
        .partial_o (partial[g])
      );
    end
  endgenerate

  // Channel accumulation
  mvc_ram #(
    .WIDTH (mvc_pkg::SUM_W),
    .DEPTH (2 ** AW)
  ) u_accum (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i ({meta_q[NS].orow, meta_q[NS].ocol}),
    .wdata_i (total),
    .raddr_i ({meta_q[NS-1].orow, meta_q[NS-1].ocol}),
    .rdata_o (acc_rd)
  );

  assign total  = partial[K-1] + (meta_q[NS].first_ch ? '0 : acc_rd);
  assign acc_we = meta_q[NS].valid && meta_q[NS].emit;
  assign push   = acc_we && meta_q[NS].last_ch;

  always_comb begin
    push_word.conv_sum = total;
    push_word.row      = mvc_pkg::POS_W'(meta_q[NS].orow);
    push_word.col      = mvc_pkg::POS_W'(meta_q[NS].ocol);
    push_word.last     = meta_q[NS].last;
  end

  // Output FIFO with credit toward the words in flight
  assign pop = out_valid_o && !out_stall_i;
  assign inc = meta_new.valid && meta_new.emit && meta_new.last_ch;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      inflight_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FW'(1);
      end
      cnt_q      <= cnt_q + CNTW'(push) - CNTW'(pop);
      inflight_q <= inflight_q + CNTW'(inc) - CNTW'(push);
    end
  end

  assign in_stall_o = ((CNTW+1)'(inflight_q) + (CNTW+1)'(cnt_q)) >= (CNTW+1)'(FD);

  assign out_valid_o = (cnt_q != '0);
  assign conv_sum_o  = fifo_q[rd_ptr_q].conv_sum;
  assign out_row_o   = fifo_q[rd_ptr_q].row;
  assign out_col_o   = fifo_q[rd_ptr_q].col;
  assign last_o      = fifo_q[rd_ptr_q].last;

endmodule
`default_nettype wire

[sv/mvc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/mvc_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvc_cell: one kernel row of the convolution chain
// Holds one window row, one kernel row and, in every cell but the last, a
// line buffer. Multiplies the row, delays the row sum to line up with its
// neighbor and adds the partial sum handed in from the previous cell.
// ----------------------------------------------------------------------------
module mvc_cell #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 64,
  parameter int CELL_IDX    = 0
) (
  input  wire logic                                clk_i,
  input  wire mvc_pkg::cell_ctrl_t                 ctrl_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        rd_addr_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        wr_addr_i,
  input  wire logic signed [mvc_pkg::SAMPLE_W-1:0] col_i,
  output      logic signed [mvc_pkg::SAMPLE_W-1:0] col_o,
  input  wire logic signed [mvc_pkg::SUM_W-1:0]    partial_i,
  output      logic signed [mvc_pkg::SUM_W-1:0]    partial_o
);

  localparam int K   = KERNEL_SIZE;
  localparam int KLO = CELL_IDX * KERNEL_SIZE;

  logic signed [mvc_pkg::SAMPLE_W-1:0] col;
  logic signed [mvc_pkg::SAMPLE_W-1:0] win_q  [K];
  logic signed [mvc_pkg::SAMPLE_W-1:0] kern_q [K];
  logic signed [mvc_pkg::PROD_W-1:0]   prod_q [K];
  logic signed [mvc_pkg::SUM_W-1:0]    rowsum;
  logic signed [mvc_pkg::SUM_W-1:0]    rowsum_q;
  logic signed [mvc_pkg::SUM_W-1:0]    dly_out;
  logic signed [mvc_pkg::SUM_W-1:0]    partial_q;

  generate
    if (CELL_IDX < KERNEL_SIZE - 1) begin : g_line
      logic [mvc_pkg::SAMPLE_W-1:0] rd_data;

      mvc_ram #(
        .WIDTH (mvc_pkg::SAMPLE_W),
        .DEPTH (MAX_WIDTH)
      ) u_line (
        .clk_i   (clk_i),
        .we_i    (ctrl_i.shift_en),
        .waddr_i (wr_addr_i),
        .wdata_i (col_i),
        .raddr_i (rd_addr_i),
        .rdata_o (rd_data)
      );

      assign col = rd_data;
    end else begin : g_newest
      assign col = col_i;
    end
  endgenerate

  assign col_o = col;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      for (int b = 0; b < K - 1; b++) begin
        win_q[b] <= win_q[b+1];
      end
      win_q[K-1] <= col;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < K; b++) begin
      if (ctrl_i.kload_en && (int'(ctrl_i.kload_idx) == KLO + b)) begin
        kern_q[b] <= ctrl_i.kload_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < K; b++) begin
      prod_q[b] <= win_q[b] * kern_q[b];
    end
  end

  always_comb begin
    rowsum = '0;
    for (int b = 0; b < K; b++) begin
      rowsum = rowsum + mvc_pkg::SUM_W'(prod_q[b]);
    end
  end

  always_ff @(posedge clk_i) begin
    rowsum_q <= rowsum;
  end

  generate
    if (CELL_IDX == 0) begin : g_nodly
      assign dly_out = rowsum_q;
    end else begin : g_dly
      logic signed [mvc_pkg::SUM_W-1:0] dly_q [CELL_IDX];

      always_ff @(posedge clk_i) begin
        dly_q[0] <= rowsum_q;
        for (int i = 1; i < CELL_IDX; i++) begin
          dly_q[i] <= dly_q[i-1];
        end
      end

      assign dly_out = dly_q[CELL_IDX-1];
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    partial_q <= partial_i + dly_out;
  end

  assign partial_o = partial_q;

endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multichannel_valid_convolution_top
// Streams coefficient loads and pixel planes through the valid/stall input,
// predicts every channel-summed window sum, and compares each delivered word
// field by field. Image shape and channel count change between phases, with
// out-of-range register values, partial images and random idling on both
// sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int K              = 3;
  localparam int MAX_W          = 64;
  localparam int MAX_H          = 64;
  localparam int MAX_CH         = 16;
  localparam int DRAIN_CYCLES   = 2 * (K + 4) + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WORD_TARGET    = 1850;
  localparam logic [mvc_pkg::CFG_IX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    mvc_pkg::cmd_e                       cmd;
    logic [mvc_pkg::IDX_W-1:0]           tap;
    logic signed [mvc_pkg::SAMPLE_W-1:0] sample;
  } in_word_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  mvc_pkg::cmd_e                       command_i = mvc_pkg::CMD_LOAD;
  logic [mvc_pkg::IDX_W-1:0]           coeff_index_i = '0;
  logic signed [mvc_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [mvc_pkg::SUM_W-1:0]    conv_sum_o;
  logic [mvc_pkg::POS_W-1:0]           out_row_o;
  logic [mvc_pkg::POS_W-1:0]           out_col_o;
  logic                                last_o;
  logic                                cfg_we_i = 1'b0;
  logic [mvc_pkg::CFG_IX_W-1:0]        cfg_index_i = '0;
  logic [mvc_pkg::CFG_W-1:0]           cfg_data_i = '0;

  multichannel_valid_convolution_top #(
    .KERNEL_SIZE (K),
    .MAX_WIDTH   (MAX_W),
    .MAX_HEIGHT  (MAX_H),
    .MAX_CHANNELS(MAX_CH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .coeff_index_i(coeff_index_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .conv_sum_o   (conv_sum_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predictor state
  logic [mvc_pkg::CFG_W-1:0]           width_reg;
  logic [mvc_pkg::CFG_W-1:0]           height_reg;
  logic [mvc_pkg::CHAN_W-1:0]          chan_reg;
  logic signed [mvc_pkg::SAMPLE_W-1:0] coeff_mem [K*K];
  logic signed [mvc_pkg::SAMPLE_W-1:0] line_mem [K-1][MAX_W];
  logic signed [mvc_pkg::SAMPLE_W-1:0] window [K*K];
  logic signed [mvc_pkg::SUM_W-1:0]    partial_sums [MAX_H*MAX_W];
  int unsigned                         row_at;
  int unsigned                         col_at;
  int unsigned                         plane_at;

  in_word_t           pending_words [$];
  mvc_pkg::out_word_t sums_due [$];
  in_word_t           cur_word;
  int                 queued_words = 0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 10;
  int                 recv_stall_pct = 10;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic step_conv(input in_word_t wd);
    int unsigned                         w, h, nch, c, r, a, b, addr;
    logic signed [mvc_pkg::SAMPLE_W-1:0] column [K];
    logic signed [mvc_pkg::SUM_W-1:0]    total;
    logic signed [mvc_pkg::PROD_W-1:0]   prod;
    mvc_pkg::out_word_t                  res;
    w   = clamp_to(width_reg, K, MAX_W);
    h   = clamp_to(height_reg, K, MAX_H);
    nch = clamp_to(chan_reg, 1, MAX_CH);
    if (wd.cmd == mvc_pkg::CMD_LOAD) begin
      if (wd.tap < K * K) coeff_mem[wd.tap] = wd.sample;
      return;
    end
    c = col_at;
    r = row_at;
    for (a = 0; a < K - 1; a++) column[a] = line_mem[a][c];
    column[K-1] = wd.sample;
    for (a = 0; a < K - 1; a++) line_mem[a][c] = column[a+1];
    for (a = 0; a < K; a++) begin
      for (b = 0; b < K - 1; b++) window[a*K+b] = window[a*K+b+1];
      window[a*K+K-1] = column[a];
    end
    if (r >= K - 1 && c >= K - 1) begin
      addr  = (r - (K - 1)) * MAX_W + (c - (K - 1));
      total = '0;
      for (a = 0; a < K * K; a++) begin
        prod  = window[a] * coeff_mem[a];
        total = total + prod;
      end
      if (plane_at != 0) total = total + partial_sums[addr];
      partial_sums[addr] = total;
      if (plane_at == nch - 1) begin
        res.conv_sum = total;
        res.row      = mvc_pkg::POS_W'(r - (K - 1));
        res.col      = mvc_pkg::POS_W'(c - (K - 1));
        res.last     = (r == h - 1) && (c == w - 1);
        sums_due.insert(sums_due.size(), res);
      end
    end
    col_at = c + 1;
    if (col_at >= w) begin
      col_at = 0;
      row_at = r + 1;
      if (row_at >= h) begin
        row_at = 0;
        plane_at++;
        if (plane_at >= nch) plane_at = 0;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) step_conv(cur_word);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          in_valid_i    <= 1'b1;
          command_i     <= cur_word.cmd;
          coeff_index_i <= cur_word.tap;
          sample_i      <= cur_word.sample;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mvc_pkg::out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected word sum %0d row %0d col %0d last %0b", $time,
                   conv_sum_o, out_row_o, out_col_o, last_o);
          mismatches++;
        end else begin
          want = sums_due.pop_front();
          check_field("conv_sum", want.conv_sum, conv_sum_o);
          check_field("out_row", {58'd0, want.row}, {58'd0, out_row_o});
          check_field("out_col", {58'd0, want.col}, {58'd0, out_col_o});
          check_field("last", {63'd0, want.last}, {63'd0, last_o});
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [mvc_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(19))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return mvc_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [mvc_pkg::CFG_W-1:0] raw_dim(input int unsigned eff,
                                                        input int unsigned hi);
    if (eff == K) return mvc_pkg::CFG_W'($urandom_range(0, K));
    if (eff == hi) return mvc_pkg::CFG_W'($urandom_range(hi, 127));
    return mvc_pkg::CFG_W'(eff);
  endfunction

  function automatic logic [mvc_pkg::CFG_W-1:0] raw_chans(input int unsigned eff);
    int unsigned low;
    if (eff == MAX_CH) low = $urandom_range(MAX_CH, 31);
    else if (eff == 1) low = $urandom_range(0, 1);
    else low = eff;
    return {2'($urandom), mvc_pkg::CHAN_W'(low)};
  endfunction

  task automatic push_word(input mvc_pkg::cmd_e cmd, input logic [mvc_pkg::IDX_W-1:0] tap,
                           input logic signed [mvc_pkg::SAMPLE_W-1:0] s);
    in_word_t wd;
    wd.cmd    = cmd;
    wd.tap    = tap;
    wd.sample = s;
    pending_words.insert(pending_words.size(), wd);
    queued_words++;
  endtask

  task automatic stream_pixels(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0)
        push_word(mvc_pkg::CMD_LOAD, mvc_pkg::IDX_W'($urandom_range(15)), pick_sample());
      push_word(mvc_pkg::CMD_PIXEL, mvc_pkg::IDX_W'($urandom), pick_sample());
    end
  endtask

  task automatic load_kernel();
    int i;
    for (i = 0; i < K * K; i++)
      push_word(mvc_pkg::CMD_LOAD, mvc_pkg::IDX_W'(i), pick_sample());
  endtask

  task automatic write_reg(input logic [mvc_pkg::CFG_IX_W-1:0] idx,
                           input logic [mvc_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      mvc_pkg::CFG_WIDTH:    width_reg = data;
      mvc_pkg::CFG_HEIGHT:   height_reg = data;
      mvc_pkg::CFG_CHANNELS: chan_reg = data[mvc_pkg::CHAN_W-1:0];
      default: ;
    endcase
    if (idx != CFG_SPARE) begin
      row_at   = 0;
      col_at   = 0;
      plane_at = 0;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || sums_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int i, j, ph, kind, roll, n, w, h, ch;
    width_reg  = mvc_pkg::CFG_W'(MAX_W);
    height_reg = mvc_pkg::CFG_W'(MAX_H);
    chan_reg   = mvc_pkg::CHAN_W'(1);
    row_at     = 0;
    col_at     = 0;
    plane_at   = 0;
    for (i = 0; i < K * K; i++) window[i] = '0;
    for (i = 0; i < K - 1; i++)
      for (j = 0; j < MAX_W; j++) line_mem[i][j] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset shape: extreme taps, out-of-range tap indexes, three full-width rows
    @(negedge clk_i);
    for (i = 0; i < K * K; i++)
      push_word(mvc_pkg::CMD_LOAD, mvc_pkg::IDX_W'(i),
                (i == 0) ? 16'sh8000 : (i == K * K - 1) ? 16'sh7fff :
                mvc_pkg::SAMPLE_W'($urandom));
    push_word(mvc_pkg::CMD_LOAD, mvc_pkg::IDX_W'(K * K), 16'sh7fff);
    push_word(mvc_pkg::CMD_LOAD, mvc_pkg::IDX_W'(15), 16'sh8000);
    stream_pixels(K * MAX_W);

    // largest positive and negative sums
    wait_idle();
    write_reg(mvc_pkg::CFG_WIDTH, mvc_pkg::CFG_W'(K));
    write_reg(mvc_pkg::CFG_HEIGHT, mvc_pkg::CFG_W'(K));
    write_reg(mvc_pkg::CFG_CHANNELS, mvc_pkg::CFG_W'(1));
    @(negedge clk_i);
    for (i = 0; i < K * K; i++) push_word(mvc_pkg::CMD_LOAD, mvc_pkg::IDX_W'(i), 16'sh8000);
    for (i = 0; i < K * K; i++) push_word(mvc_pkg::CMD_PIXEL, '0, 16'sh8000);
    for (i = 0; i < K * K; i++) push_word(mvc_pkg::CMD_PIXEL, '1, 16'sh7fff);

    for (ph = 0; queued_words < WORD_TARGET; ph++) begin
      wait_idle();
      send_idle_pct  = (ph == 2) ? 0 : 10;
      recv_stall_pct = (ph == 2) ? 0 : 10;
      roll = $urandom_range(99);
      if (ph < 4 || roll >= 20) begin
        kind = (ph < 4) ? ph : $urandom_range(9);
        case (kind)
          0: begin
            w = MAX_W; h = $urandom_range(K, K + 1); ch = 1;
          end
          1: begin
            w = $urandom_range(K, K + 1); h = MAX_H; ch = 1;
          end
          2: begin
            w = $urandom_range(K, K + 1); h = $urandom_range(K, K + 1); ch = MAX_CH;
          end
          4: begin
            w = K; h = K; ch = $urandom_range(1, 3);
          end
          default: begin
            w = $urandom_range(K, 10); h = $urandom_range(K, 10); ch = $urandom_range(1, 4);
          end
        endcase
        write_reg(mvc_pkg::CFG_CHANNELS, raw_chans(ch));
        write_reg(mvc_pkg::CFG_WIDTH, raw_dim(w, MAX_W));
        write_reg(mvc_pkg::CFG_HEIGHT, raw_dim(h, MAX_H));
        if ($urandom_range(3) == 0) write_reg(CFG_SPARE, mvc_pkg::CFG_W'($urandom));
        @(negedge clk_i);
        if (ph == 0 || $urandom_range(2) == 0) load_kernel();
      end else begin
        if (roll < 8) write_reg(CFG_SPARE, mvc_pkg::CFG_W'($urandom));
        @(negedge clk_i);
      end
      w  = clamp_to(width_reg, K, MAX_W);
      h  = clamp_to(height_reg, K, MAX_H);
      ch = clamp_to(chan_reg, 1, MAX_CH);
      n  = w * h * ch;
      case ($urandom_range(3))
        0: n = $urandom_range(1, n);
        1: n = n + $urandom_range(0, w * h);
        default: ;
      endcase
      if (queued_words + n > WORD_TARGET + 20) n = WORD_TARGET + 20 - queued_words;
      stream_pixels(n);
    end

    wait_idle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
